FILE: rtl/core/fir_filter_stream_macros.svh
// Assertion helpers shared by the filter RTL.
// Each expects clk and rst in scope; checks are off while rst is high.
`ifndef FIR_FILTER_STREAM_MACROS_SVH
`define FIR_FILTER_STREAM_MACROS_SVH

// Same-cycle implication.
`define FIR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fir_filter_stream: assertion failed");

// Next-cycle implication.
`define FIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fir_filter_stream: assertion failed");

`endif

FILE: rtl/core/fir_pkg.sv
`timescale 1ns / 1ps

package fir_pkg;

  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 40;

  localparam int COEF_BITS     = 16;
  localparam int KIND_BITS     = 2;
  localparam int TAP_IDX_BITS  = 6;
  localparam int TAPS_CFG_BITS = 7;
  localparam int SHIFT_BITS    = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 7;

  localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_COEF   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_FLUSH  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_TAPS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RESULT_SHIFT = 2'd1;

  localparam logic [TAPS_CFG_BITS-1:0] ACTIVE_TAPS_RESET  = 7'd64;
  localparam logic [SHIFT_BITS-1:0]    RESULT_SHIFT_RESET = 5'd15;

  // Tags that travel with one operand pair through the MAC pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

FILE: rtl/core/fir_if.sv
`timescale 1ns / 1ps

interface fir_in_if #(
  parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) ();
  logic                                   valid;
  logic                                   ready;
  logic [fir_pkg::KIND_BITS-1:0]          kind;
  logic signed [SAMPLE_BITS-1:0]          sample_in;
  logic [fir_pkg::TAP_IDX_BITS-1:0]       tap_index;
  logic signed [fir_pkg::COEF_BITS-1:0]   tap_value;

  modport source (output valid, kind, sample_in, tap_index, tap_value, input ready);
  modport sink   (input valid, kind, sample_in, tap_index, tap_value, output ready);
endinterface

interface fir_out_if #(
  parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_sample;
  logic                          clipped;
  logic                          last_of_run;

  modport source (output valid, filtered_sample, clipped, last_of_run, input ready);
  modport sink   (input valid, filtered_sample, clipped, last_of_run, output ready);
endinterface

interface fir_cfg_if ();
  logic                               valid;
  logic                               ready;
  logic [fir_pkg::CFG_IDX_BITS-1:0]   index;
  logic [fir_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/fir_mac.sv
`timescale 1ns / 1ps

module fir_mac #(
  parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = fir_pkg::ACC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fir_pkg::mac_ctl_t                    ctl,
  input  logic signed [fir_pkg::COEF_BITS-1:0] coef,
  input  logic signed [SAMPLE_BITS-1:0]        smp,
  output logic signed [ACC_BITS-1:0]           acc,
  output logic                                 done
);

  localparam int PROD_BITS = fir_pkg::COEF_BITS + SAMPLE_BITS;

  logic signed [PROD_BITS-1:0] prod;
  fir_pkg::mac_ctl_t           prod_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
      done     <= 1'b0;
    end else begin
      prod_ctl <= ctl;
      done     <= prod_ctl.valid && prod_ctl.last;
    end
  end

  // Payload: product, then wrap-around accumulate (first term reloads).
  always_ff @(posedge clk) begin
    prod <= coef * smp;
    if (prod_ctl.valid) begin
      if (prod_ctl.first) begin
        acc <= ACC_BITS'(prod);
      end else begin
        acc <= acc + ACC_BITS'(prod);
      end
    end
  end

endmodule

FILE: rtl/core/fir_filter_stream.sv
// Direct-form FIR filter over up to MAX_TAPS taps with one shared multiplier and
// accumulator. With n = active_taps clamped to 1..MAX_TAPS, an accepted sample request
// puts its result in the output register, and the next request can be accepted in the
// cycle after that. The steps are: one multiply-accumulate issued per tap for n taps
// from the coefficient and delay-line memories (one registered read each per cycle), a
// drain of the multiplier and accumulator while the delay line takes the new sample, a
// rounding step, a shift/saturate step and the hand-off to the output register. A flush
// request runs that sequence n - 1 times with zero input, one output per run. The
// hand-off waits while the output register still holds an unaccepted result, and the
// request is stretched by that stall. Coefficient writes, unused request kinds and a
// single-tap flush finish in the accepting cycle. The block takes no request while a
// run is in progress; a finished result sits in the output register, so the next
// request can be accepted while it waits. Coefficients and delay line read as zero
// until written after reset; there is no clearing pass.
`timescale 1ns / 1ps
`include "fir_filter_stream_macros.svh"

module fir_filter_stream #(
  parameter int MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = fir_pkg::ACC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fir_cfg_if.sink     cfg,
  fir_in_if.sink      cmd,
  fir_out_if.source   res
);

  localparam int DL_DEPTH = MAX_TAPS - 1;
  localparam int DW       = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;
  localparam int KW       = $clog2(MAX_TAPS);
  localparam int TAPS_W   = $clog2(MAX_TAPS + 1);
  localparam int RW       = ACC_BITS + 1;
  localparam int CB       = fir_pkg::COEF_BITS;

  localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_SHIFT,
    S_EMIT
  } state_t;

  // Configuration registers
  logic [fir_pkg::TAPS_CFG_BITS-1:0] active_taps;
  logic [fir_pkg::SHIFT_BITS-1:0]    result_shift;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps  <= fir_pkg::ACTIVE_TAPS_RESET;
      result_shift <= fir_pkg::RESULT_SHIFT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        fir_pkg::REG_ACTIVE_TAPS:  active_taps  <= cfg.data[fir_pkg::TAPS_CFG_BITS-1:0];
        fir_pkg::REG_RESULT_SHIFT: result_shift <= cfg.data[fir_pkg::SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp tap count to 1..MAX_TAPS
  logic [TAPS_W-1:0] taps_n;
  always_comb begin
    if (active_taps == '0) begin
      taps_n = TAPS_W'(1);
    end else if (active_taps > fir_pkg::TAPS_CFG_BITS'(MAX_TAPS)) begin
      taps_n = TAPS_W'(MAX_TAPS);
    end else begin
      taps_n = TAPS_W'(active_taps);
    end
  end

  state_t                        state;
  logic [KW-1:0]                 k;
  logic [DW-1:0]                 rd_ptr;
  logic [DW-1:0]                 newest;
  logic [KW-1:0]                 runs_left;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  fir_pkg::mac_ctl_t             rd_ctl;
  logic                          rd_use_x;
  logic signed [RW-1:0]          rnd_q;
  logic signed [SAMPLE_BITS-1:0] sat_q;
  logic                          clip_q;
  logic                          res_valid_q;
  logic signed [SAMPLE_BITS-1:0] res_sample_q;
  logic                          res_clip_q;
  logic                          res_last_q;

  logic                          cmd_acc;
  logic                          tap_last;
  logic                          out_free;
  logic                          coef_we;
  logic [DW-1:0]                 dl_wr_addr;
  logic [DW-1:0]                 rd_ptr_inc;

  logic signed [ACC_BITS-1:0]    acc;
  logic                          mac_done;

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_acc    = cmd.valid && cmd.ready;
  assign tap_last   = (TAPS_W'(k) == taps_n - TAPS_W'(1));
  assign out_free   = !res_valid_q || res.ready;
  assign coef_we    = cmd_acc && (cmd.kind == fir_pkg::KIND_COEF) &&
                      ({1'b0, cmd.tap_index} < (fir_pkg::TAP_IDX_BITS + 1)'(MAX_TAPS));
  assign dl_wr_addr = (newest == '0) ? DW'(DL_DEPTH - 1) : newest - DW'(1);
  assign rd_ptr_inc = (rd_ptr == DW'(DL_DEPTH - 1)) ? '0 : rd_ptr + DW'(1);

  // Coefficient memory, zero until written
  logic signed [CB-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]  coef_vld;
  logic signed [CB-1:0] coef_q;
  logic                 coef_vq;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[cmd.tap_index[KW-1:0]] <= cmd.tap_value;
    end
    coef_q <= coef_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      coef_vq  <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld[cmd.tap_index[KW-1:0]] <= 1'b1;
      end
      coef_vq <= coef_vld[k];
    end
  end

  // Delay line as a circular buffer: sample j steps back sits at newest + j - 1
  logic signed [SAMPLE_BITS-1:0] dl_mem [DL_DEPTH];
  logic [DL_DEPTH-1:0]           dl_vld;
  logic signed [SAMPLE_BITS-1:0] dl_q;
  logic                          dl_vq;
  logic                          dl_we;

  assign dl_we = (state == S_DRAIN) && mac_done;

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_wr_addr] <= x_reg;
    end
    dl_q <= dl_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_vld <= '0;
      dl_vq  <= 1'b0;
    end else begin
      if (dl_we) begin
        dl_vld[dl_wr_addr] <= 1'b1;
      end
      dl_vq <= dl_vld[rd_ptr];
    end
  end

  // Shared multiply-accumulate
  logic signed [CB-1:0]          mac_coef;
  logic signed [SAMPLE_BITS-1:0] mac_smp;

  assign mac_coef = coef_vq ? coef_q : '0;
  assign mac_smp  = rd_use_x ? x_reg : (dl_vq ? dl_q : '0);

  fir_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .coef (mac_coef),
    .smp  (mac_smp),
    .acc  (acc),
    .done (mac_done)
  );

  // Round half up, then floor shift and saturate
  logic signed [RW-1:0] bias;
  logic signed [RW-1:0] shifted;

  assign bias    = (result_shift == '0) ? '0 : (RW'(1) << (result_shift - 1'b1));
  assign shifted = rnd_q >>> result_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_ctl      <= '0;
      res_valid_q <= 1'b0;
      runs_left   <= '0;
      newest      <= '0;
      k           <= '0;
      rd_ptr      <= '0;
    end else begin
      rd_ctl <= '0;
      if (res.valid && res.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          k      <= '0;
          rd_ptr <= newest;
          if (cmd_acc) begin
            case (cmd.kind)
              fir_pkg::KIND_SAMPLE: begin
                x_reg     <= cmd.sample_in;
                runs_left <= KW'(1);
                state     <= S_MAC;
              end
              fir_pkg::KIND_FLUSH: begin
                x_reg     <= '0;
                runs_left <= KW'(taps_n - TAPS_W'(1));
                if (taps_n != TAPS_W'(1)) begin
                  state <= S_MAC;
                end
              end
              default: ;
            endcase
          end
        end
        S_MAC: begin
          rd_ctl   <= '{valid: 1'b1, first: (k == '0), last: tap_last};
          rd_use_x <= (k == '0);
          k        <= k + KW'(1);
          if (k != '0) begin
            rd_ptr <= rd_ptr_inc;
          end
          if (tap_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (mac_done) begin
            newest <= dl_wr_addr;
            state  <= S_ROUND;
          end
        end
        S_ROUND: begin
          rnd_q <= RW'(acc) + bias;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (shifted > SAT_HI) begin
            sat_q  <= SAMPLE_BITS'(SAT_HI);
            clip_q <= 1'b1;
          end else if (shifted < SAT_LO) begin
            sat_q  <= SAMPLE_BITS'(SAT_LO);
            clip_q <= 1'b1;
          end else begin
            sat_q  <= SAMPLE_BITS'(shifted);
            clip_q <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            res_valid_q  <= 1'b1;
            res_sample_q <= sat_q;
            res_clip_q   <= clip_q;
            res_last_q   <= (runs_left == KW'(1));
            runs_left    <= runs_left - KW'(1);
            k            <= '0;
            rd_ptr       <= newest;
            if (runs_left == KW'(1)) begin
              state <= S_IDLE;
            end else begin
              state <= S_MAC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid           = res_valid_q;
  assign res.filtered_sample = res_sample_q;
  assign res.clipped         = res_clip_q;
  assign res.last_of_run     = res_last_q;

  `FIR_ASSERT_NEXT(a_sample_goes_busy, cmd_acc && (cmd.kind == fir_pkg::KIND_SAMPLE), !cmd.ready)
  `FIR_ASSERT_IMPL(a_run_pending, state != S_IDLE, runs_left != '0)
  `FIR_ASSERT_IMPL(a_tap_in_range, state == S_MAC, TAPS_W'(k) < taps_n)
  `FIR_ASSERT_IMPL(a_mac_done_in_drain, mac_done, state == S_DRAIN)

endmodule

FILE: tb/fir_filter_stream_test.sv
`timescale 1ns / 1ps

module fir_filter_stream_test;

  localparam int SAMPLE_W = fir_pkg::SAMPLE_BITS_DEF;
  localparam int COEF_W   = fir_pkg::COEF_BITS;
  localparam logic [fir_pkg::KIND_BITS-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [fir_pkg::CFG_IDX_BITS-1:0] REG_UNUSED  = 2'd3;
  localparam int TAPS      = fir_pkg::MAX_TAPS_DEF;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       clipped;
    logic                       last;
  } fir_output_t;

  logic clk = 1'b0;
  logic rst;

  fir_cfg_if cfg_bus ();
  fir_in_if  in_bus ();
  fir_out_if out_bus ();

  fir_filter_stream uut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .cmd(in_bus),
    .res(out_bus)
  );

  always #5 clk = ~clk;

  // filter state as the block should hold it
  logic signed [SAMPLE_W-1:0]             sample_history [TAPS-1];
  logic signed [COEF_W-1:0]               coef_mem [TAPS];
  logic [fir_pkg::TAPS_CFG_BITS-1:0]      taps_cfg;
  logic [fir_pkg::SHIFT_BITS-1:0]         shift_cfg;

  fir_output_t expected_outputs [$];

  int  error_count = 0;
  int  requests_accepted = 0;
  int  outputs_checked = 0;
  int  settings_written = 0;
  bit  idle_on = 1'b1;
  int  hold_cycles = 0;

  function automatic int taps_used();
    if (taps_cfg == 0) return 1;
    if (taps_cfg > TAPS) return TAPS;
    return int'(taps_cfg);
  endfunction

  // One multiply-accumulate pass: shifts x in and queues the output it gives.
  function automatic void filter_sample(logic signed [SAMPLE_W-1:0] x, logic last);
    int n;
    int k;
    longint acc;
    fir_output_t rec;
    n = taps_used();
    acc = longint'(coef_mem[0]) * longint'(x);
    for (k = 1; k < n; k++)
      acc += longint'(coef_mem[k]) * longint'(sample_history[k-1]);
    for (k = TAPS - 2; k > 0; k--)
      sample_history[k] = sample_history[k-1];
    sample_history[0] = x;
    // wrap to the accumulator width
    acc = (acc <<< (64 - fir_pkg::ACC_BITS_DEF)) >>> (64 - fir_pkg::ACC_BITS_DEF);
    if (shift_cfg != 0) begin
      acc = acc + (longint'(1) << (shift_cfg - 1));
      acc = acc >>> shift_cfg;
    end
    rec.clipped = 1'b0;
    if (acc > SAMPLE_MAX) begin
      acc = SAMPLE_MAX;
      rec.clipped = 1'b1;
    end else if (acc < SAMPLE_MIN) begin
      acc = SAMPLE_MIN;
      rec.clipped = 1'b1;
    end
    rec.value = acc[SAMPLE_W-1:0];
    rec.last = last;
    expected_outputs.push_back(rec);
  endfunction

  function automatic void predict_request(logic [fir_pkg::KIND_BITS-1:0] req_kind,
                                          logic signed [SAMPLE_W-1:0] sample,
                                          logic [fir_pkg::TAP_IDX_BITS-1:0] idx,
                                          logic signed [COEF_W-1:0] coef);
    int n;
    int i;
    case (req_kind)
      fir_pkg::KIND_SAMPLE: filter_sample(sample, 1'b1);
      fir_pkg::KIND_COEF:   coef_mem[idx] = coef;
      fir_pkg::KIND_FLUSH: begin
        n = taps_used() - 1;
        for (i = 0; i < n; i++)
          filter_sample('0, i == n - 1);
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [fir_pkg::KIND_BITS-1:0] req_kind,
                              input logic signed [SAMPLE_W-1:0] sample,
                              input logic [fir_pkg::TAP_IDX_BITS-1:0] idx,
                              input logic signed [COEF_W-1:0] coef);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= req_kind;
    in_bus.sample_in <= sample;
    in_bus.tap_index <= idx;
    in_bus.tap_value <= coef;
    do @(posedge clk); while (!in_bus.ready);
    predict_request(req_kind, sample, idx, coef);
    requests_accepted++;
  endtask

  task automatic write_register(input logic [fir_pkg::CFG_IDX_BITS-1:0] index,
                                input logic [fir_pkg::CFG_DATA_BITS-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (index)
      fir_pkg::REG_ACTIVE_TAPS:  taps_cfg = data;
      fir_pkg::REG_RESULT_SHIFT: shift_cfg = data[fir_pkg::SHIFT_BITS-1:0];
      default: ;
    endcase
    settings_written++;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop the request line and let the block drain before touching registers.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_outputs.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_W'(SAMPLE_MAX);
      1:       return SAMPLE_W'(SAMPLE_MIN);
      2:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] random_coef();
    if ($urandom_range(0, 1))
      return COEF_W'($urandom_range(0, 8191)) - 16'sd4096;
    return COEF_W'($urandom);
  endfunction

  task automatic test_impulse_response();
    wait_idle();
    send_request(fir_pkg::KIND_COEF, '0, 6'd0, 16'sh7fff);
    send_request(fir_pkg::KIND_COEF, '0, 6'd1, 16'sh8000);
    send_request(fir_pkg::KIND_COEF, '0, 6'd5, 16'sd12345);
    send_request(fir_pkg::KIND_COEF, '0, 6'd63, -16'sd1);
    send_request(fir_pkg::KIND_SAMPLE, 16'sh7fff, '0, '0);
    send_request(fir_pkg::KIND_SAMPLE, 16'sh8000, '0, '0);
    send_request(fir_pkg::KIND_SAMPLE, 16'sd1, '0, '0);
    send_request(fir_pkg::KIND_SAMPLE, -16'sd1, '0, '0);
    send_request(fir_pkg::KIND_SAMPLE, '0, '0, '0);
    send_request(KIND_UNUSED, random_sample(), 6'($urandom), random_coef());
    send_request(fir_pkg::KIND_FLUSH, random_sample(), 6'($urandom), random_coef());
  endtask

  task automatic test_register_limits();
    wait_idle();
    write_register(fir_pkg::REG_ACTIVE_TAPS, 7'd2);
    write_register(fir_pkg::REG_RESULT_SHIFT, 7'd0);
    send_request(fir_pkg::KIND_COEF, '0, 6'd0, 16'sh8000);
    send_request(fir_pkg::KIND_COEF, '0, 6'd1, 16'sh8000);
    send_request(fir_pkg::KIND_SAMPLE, 16'sh8000, '0, '0);
    send_request(fir_pkg::KIND_SAMPLE, 16'sh8000, '0, '0);
    send_request(fir_pkg::KIND_SAMPLE, 16'sh7fff, '0, '0);
    send_request(fir_pkg::KIND_FLUSH, '0, '0, '0);
    // a single tap flush gives nothing and leaves the delay line alone
    wait_idle();
    write_register(fir_pkg::REG_ACTIVE_TAPS, 7'd1);
    send_request(fir_pkg::KIND_FLUSH, '0, '0, '0);
    send_request(fir_pkg::KIND_SAMPLE, 16'sd100, '0, '0);
    wait_idle();
    write_register(fir_pkg::REG_RESULT_SHIFT, 7'd31);
    write_register(fir_pkg::REG_ACTIVE_TAPS, 7'd0);
    send_request(fir_pkg::KIND_SAMPLE, 16'sh8000, '0, '0);
    send_request(fir_pkg::KIND_SAMPLE, 16'sh7fff, '0, '0);
    wait_idle();
    write_register(fir_pkg::REG_ACTIVE_TAPS, 7'd127);
    write_register(REG_UNUSED, 7'h55);
    send_request(fir_pkg::KIND_SAMPLE, 16'sd12345, '0, '0);
  endtask

  task automatic test_random_mix(input int count,
                                 input logic [fir_pkg::TAPS_CFG_BITS-1:0] taps,
                                 input logic [fir_pkg::SHIFT_BITS-1:0] shift,
                                 input int flush_pct);
    int i;
    int pick;
    wait_idle();
    write_register(fir_pkg::REG_ACTIVE_TAPS, taps);
    // upper data bits are don't-care for the shift register
    write_register(fir_pkg::REG_RESULT_SHIFT, {2'($urandom), shift});
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < flush_pct)
        send_request(fir_pkg::KIND_FLUSH, random_sample(), 6'($urandom), random_coef());
      else if (pick < flush_pct + 15)
        send_request(fir_pkg::KIND_COEF, random_sample(), 6'($urandom), random_coef());
      else if (pick < flush_pct + 17)
        send_request(KIND_UNUSED, random_sample(), 6'($urandom), random_coef());
      else
        send_request(fir_pkg::KIND_SAMPLE, random_sample(), 6'($urandom), random_coef());
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_mix(20, 7'd4, 5'd14, 5);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Output side holds off while requests keep coming, so the block backs up.
  task automatic test_output_stall();
    int i;
    wait_idle();
    write_register(fir_pkg::REG_ACTIVE_TAPS, 7'd6);
    write_register(fir_pkg::REG_RESULT_SHIFT, 7'd13);
    hold_cycles = 400;
    for (i = 0; i < 25; i++)
      send_request(fir_pkg::KIND_SAMPLE, random_sample(), 6'($urandom), random_coef());
  endtask

  // output side: random stalls, then check each accepted output in order
  initial begin
    int stall;
    fir_output_t exp_out;
    out_bus.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = 0;
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else if (idle_on) begin
        stall = $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      outputs_checked++;
      if (expected_outputs.size() == 0) begin
        $error("unexpected output: filtered_sample %0d", $signed(out_bus.filtered_sample));
        error_count++;
      end else begin
        exp_out = expected_outputs.pop_front();
        if (out_bus.filtered_sample !== exp_out.value) begin
          $error("filtered_sample mismatch: expected %0d, got %0d",
                 exp_out.value, $signed(out_bus.filtered_sample));
          error_count++;
        end
        if (out_bus.clipped !== exp_out.clipped) begin
          $error("clipped mismatch: expected %0b, got %0b", exp_out.clipped, out_bus.clipped);
          error_count++;
        end
        if (out_bus.last_of_run !== exp_out.last) begin
          $error("last_of_run mismatch: expected %0b, got %0b",
                 exp_out.last, out_bus.last_of_run);
          error_count++;
        end
      end
    end
  end

  initial begin
    int k;
    rst <= 1'b1;
    in_bus.valid     <= 1'b0;
    in_bus.kind      <= fir_pkg::KIND_SAMPLE;
    in_bus.sample_in <= '0;
    in_bus.tap_index <= '0;
    in_bus.tap_value <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= fir_pkg::REG_ACTIVE_TAPS;
    cfg_bus.data     <= '0;
    for (k = 0; k < TAPS - 1; k++) sample_history[k] = '0;
    for (k = 0; k < TAPS; k++) coef_mem[k] = '0;
    taps_cfg  = fir_pkg::ACTIVE_TAPS_RESET;
    shift_cfg = fir_pkg::RESULT_SHIFT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_impulse_response();
    test_register_limits();
    test_random_mix(40, 7'd8, 5'd15, 6);
    test_random_mix(30, 7'd3, 5'd0, 8);
    test_random_mix(20, 7'd64, 5'd31, 3);
    test_random_mix(30, 7'($urandom_range(1, 20)), 5'($urandom), 5);
    test_back_to_back();
    test_output_stall();

    wait_idle();
    if (expected_outputs.size() != 0) begin
      $error("%0d expected outputs never arrived", expected_outputs.size());
      error_count++;
    end
    $display("Ran %0d requests, checked %0d outputs, %0d register writes;",
             requests_accepted, outputs_checked, settings_written);
    $display("covered tap/shift extremes, saturation, flushes and a long output backlog.");
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
